// ===== design/acp_pkg.sv =====
package acp_pkg;

  // result kinds
  localparam logic [2:0] K_ECHO  = 3'd0;
  localparam logic [2:0] K_OK    = 3'd1;
  localparam logic [2:0] K_ERROR = 3'd2;
  localparam logic [2:0] K_NAME  = 3'd3;
  localparam logic [2:0] K_ARG   = 3'd4;
  localparam logic [2:0] K_END   = 3'd5;

  // request types
  localparam logic [1:0] RT_EXEC  = 2'd0;
  localparam logic [1:0] RT_QUERY = 2'd1;
  localparam logic [1:0] RT_SET   = 2'd2;

  // echo modes
  localparam logic [1:0] EM_FOLLOW = 2'd0;
  localparam logic [1:0] EM_OFF    = 2'd1;
  localparam logic [1:0] EM_ON     = 2'd2;

  // characters
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_1    = 8'h31;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_QM   = 8'h3F;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UZ   = 8'h5A;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LE   = 8'h65;
  localparam logic [7:0] CH_LT   = 8'h74;
  localparam logic [7:0] CH_DEL  = 8'h7F;

  // one result word headed for the output register
  typedef struct packed {
    logic       valid;
    logic [2:0] kind;
    logic [7:0] ch;
    logic [1:0] rtype;
    logic       last;
  } acp_res_t;

  // echo mode change requested by ATE0 / ATE1
  typedef struct packed {
    logic       valid;
    logic [1:0] mode;
  } acp_echo_upd_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[CH_UA:CH_UZ]}) r = c + 8'd32;
    return r;
  endfunction

endpackage

// ===== design/acp_ram.sv =====
module acp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/acp_judge.sv =====
module acp_judge
  import acp_pkg::*;
#(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [$clog2(BUFFER_DEPTH):0]   line_len,
  input  logic                            slot_free,
  output logic                            rd_en,
  output logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr,
  input  logic [7:0]                      rd_data,
  output acp_res_t                        res,
  output acp_echo_upd_t                   echo_upd
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int PW = AW + 1;
  localparam logic [PW-1:0] L2 = PW'(2);
  localparam logic [PW-1:0] L3 = PW'(3);
  localparam logic [PW-1:0] L4 = PW'(4);

  localparam logic [2:0] J_IDLE   = 3'd0;
  localparam logic [2:0] J_P1A    = 3'd1;  // scan: issue read
  localparam logic [2:0] J_P1D    = 3'd2;  // scan: look at char
  localparam logic [2:0] J_DECIDE = 3'd3;
  localparam logic [2:0] J_P2A    = 3'd4;  // emit: issue read
  localparam logic [2:0] J_P2D    = 3'd5;  // emit: send char
  localparam logic [2:0] J_END    = 3'd6;
  localparam logic [2:0] J_ONE    = 3'd7;  // single OK / ERROR

  logic [2:0]    st_r, st_nxt;
  logic [PW-1:0] idx_r, idx_nxt;
  logic [PW-1:0] fill_r, fill_nxt;
  logic [PW-1:0] len_r, len_nxt;
  logic [PW-1:0] sep_r, sep_nxt;
  logic [PW-1:0] end_r, end_nxt;
  logic          sep_found_r, sep_found_nxt;
  logic          sep_q_r, sep_q_nxt;
  logic [1:0]    rtype_r, rtype_nxt;
  logic [2:0]    one_kind_r, one_kind_nxt;
  logic [7:0]    c_r [4];

  logic head, is_at, is_ate, bad, q_bad, is_sep, c_wr;

  always_comb begin
    head   = (len_r >= L2) && (fold(c_r[0]) == CH_LA) && (fold(c_r[1]) == CH_LT);
    is_at  = head && (len_r == L2);
    is_ate = head && (len_r == L4) && (fold(c_r[2]) == CH_LE) &&
             ((c_r[3] == CH_0) || (c_r[3] == CH_1));
    bad    = !head || (len_r < L3) || (c_r[2] != CH_PLUS);
    q_bad  = sep_found_r && sep_q_r && (({1'b0, sep_r} + 1'b1) != {1'b0, len_r});
    is_sep = (rd_data == CH_EQ) || (rd_data == CH_QM);
  end

  always_comb begin
    st_nxt        = st_r;
    idx_nxt       = idx_r;
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    sep_nxt       = sep_r;
    end_nxt       = end_r;
    sep_found_nxt = sep_found_r;
    sep_q_nxt     = sep_q_r;
    rtype_nxt     = rtype_r;
    one_kind_nxt  = one_kind_r;
    rd_en         = 1'b0;
    rd_addr       = idx_r[AW-1:0];
    res           = '0;
    echo_upd      = '0;
    c_wr          = 1'b0;

    case (st_r)
      J_IDLE: begin
        if (start) begin
          fill_nxt      = line_len;
          idx_nxt       = '0;
          sep_found_nxt = 1'b0;
          st_nxt        = J_P1A;
        end
      end
      J_P1A: begin
        if (idx_r >= fill_r) begin
          len_nxt = fill_r;
          st_nxt  = J_DECIDE;
        end else begin
          rd_en  = 1'b1;
          st_nxt = J_P1D;
        end
      end
      J_P1D: begin
        // a zero byte cuts the line short
        if (rd_data == CH_NUL) begin
          len_nxt = idx_r;
          st_nxt  = J_DECIDE;
        end else begin
          c_wr = (idx_r < L4);
          if (!sep_found_r && (idx_r >= L3) && is_sep) begin
            sep_found_nxt = 1'b1;
            sep_nxt       = idx_r;
            sep_q_nxt     = (rd_data == CH_QM);
          end
          idx_nxt = idx_r + 1'b1;
          st_nxt  = J_P1A;
        end
      end
      J_DECIDE: begin
        if (is_at) begin
          one_kind_nxt = K_OK;
          st_nxt       = J_ONE;
        end else if (is_ate) begin
          echo_upd.valid = 1'b1;
          echo_upd.mode  = (c_r[3] == CH_0) ? EM_OFF : EM_ON;
          one_kind_nxt   = K_OK;
          st_nxt         = J_ONE;
        end else if (bad || q_bad) begin
          one_kind_nxt = K_ERROR;
          st_nxt       = J_ONE;
        end else begin
          rtype_nxt = !sep_found_r ? RT_EXEC : (sep_q_r ? RT_QUERY : RT_SET);
          end_nxt   = (sep_found_r && sep_q_r) ? sep_r : len_r;
          idx_nxt   = L3;
          st_nxt    = J_P2A;
        end
      end
      J_P2A: begin
        if (idx_r >= end_r) begin
          st_nxt = J_END;
        end else if (sep_found_r && (idx_r == sep_r)) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          rd_en  = 1'b1;
          st_nxt = J_P2D;
        end
      end
      J_P2D: begin
        if (slot_free) begin
          res.valid = 1'b1;
          res.kind  = (sep_found_r && (idx_r > sep_r)) ? K_ARG : K_NAME;
          res.ch    = rd_data;
          res.rtype = rtype_r;
          idx_nxt   = idx_r + 1'b1;
          st_nxt    = J_P2A;
        end
      end
      J_END: begin
        if (slot_free) begin
          res.valid = 1'b1;
          res.kind  = K_END;
          res.rtype = rtype_r;
          res.last  = 1'b1;
          st_nxt    = J_IDLE;
        end
      end
      J_ONE: begin
        if (slot_free) begin
          res.valid = 1'b1;
          res.kind  = one_kind_r;
          res.last  = 1'b1;
          st_nxt    = J_IDLE;
        end
      end
      default: st_nxt = J_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= J_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    idx_r       <= idx_nxt;
    fill_r      <= fill_nxt;
    len_r       <= len_nxt;
    sep_r       <= sep_nxt;
    end_r       <= end_nxt;
    sep_found_r <= sep_found_nxt;
    sep_q_r     <= sep_q_nxt;
    rtype_r     <= rtype_nxt;
    one_kind_r  <= one_kind_nxt;
    if (c_wr) begin
      c_r[idx_r[1:0]] <= rd_data;
    end
  end

endmodule

// ===== design/at_command_line_parser_unit.sv =====
// AT command line parser. Bytes from the serial link (in_rx_byte) are
// collected into a line buffer RAM; BS or DEL drops the last kept char,
// and bytes past line_capacity-1 only flag overflow. With echo on, kept
// chars, BS SP BS on erase and CR LF at line end are echoed. At CR or LF
// the line is judged: ERROR on overflow, OK for AT / ATE0 / ATE1 (case
// folded; ATE0/ATE1 switch echo off/on), ERROR without an AT+ prefix or
// with a '?' that is not last, otherwise name chars, argument chars and a
// request end carrying exec/query/set. A zero byte ends the line early.
// Each result word carries last_of_run on the final word for its byte.
// An ordinary byte is taken while idle, then its echo words go out one by
// one. A line end is judged by a scan pass over the kept chars and an emit
// pass for the name/argument chars, since every buffer access goes through
// the single registered read port of the line RAM.
// Output stalls hold the sequencer in place. Config writes are always
// accepted (cfg_ready is tied high) and must be issued while idle.
module at_command_line_parser_unit
  import acp_pkg::*;
#(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_char,
  output logic [1:0] out_request_type,
  output logic       out_last_of_run,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int PW = AW + 1;

  localparam logic CFG_LINE_CAPACITY = 1'b0;
  localparam logic CFG_ECHO_DEFAULT  = 1'b1;

  // top sequencer
  localparam logic [2:0] T_IDLE   = 3'd0;
  localparam logic [2:0] T_ECHO   = 3'd1;
  localparam logic [2:0] T_LAUNCH = 3'd2;
  localparam logic [2:0] T_OVF    = 3'd3;
  localparam logic [2:0] T_JUDGE  = 3'd4;

  // echo sequences
  localparam logic [1:0] ES_CHAR  = 2'd0;
  localparam logic [1:0] ES_ERASE = 2'd1;
  localparam logic [1:0] ES_CRLF  = 2'd2;

  logic [2:0]    st_r, st_nxt;
  logic [PW-1:0] fill_r, fill_nxt;
  logic          ovf_r, ovf_nxt;
  logic [1:0]    echo_mode_r, echo_mode_nxt;
  logic [6:0]    cap_r;
  logic          echo_def_r;
  logic [1:0]    eseq_r, eseq_nxt;
  logic [1:0]    ecnt_r, ecnt_nxt;
  logic [7:0]    echr_r, echr_nxt;
  logic          jpend_r, jpend_nxt;
  logic          jovf_r, jovf_nxt;
  logic [PW-1:0] jlen_r, jlen_nxt;

  logic          out_valid_r;
  acp_res_t      out_r;

  logic          slot_free, accept, echo_on, is_eol, is_erase, has_room;
  logic          echo_last, judge_start;
  logic [PW-1:0] cap_eff;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  acp_res_t      top_res, judge_res, emit;
  acp_echo_upd_t echo_upd;

  assign cfg_ready = 1'b1;
  assign in_ready  = (st_r == T_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    echo_on = (echo_mode_r == EM_OFF) ? 1'b0 :
              (echo_mode_r == EM_ON)  ? 1'b1 : echo_def_r;
    // capacity saturated to 2..BUFFER_DEPTH
    if (cap_r < 7'd2) begin
      cap_eff = PW'(2);
    end else if (cap_r > 7'(BUFFER_DEPTH)) begin
      cap_eff = PW'(BUFFER_DEPTH);
    end else begin
      cap_eff = cap_r[PW-1:0];
    end
    is_eol   = (in_rx_byte == CH_CR) || (in_rx_byte == CH_LF);
    is_erase = (in_rx_byte == CH_BS) || (in_rx_byte == CH_DEL);
    has_room = (({1'b0, fill_r} + 1'b1) < {1'b0, cap_eff});
    case (eseq_r)
      ES_ERASE: echo_last = (ecnt_r == 2'd2);
      ES_CRLF:  echo_last = (ecnt_r == 2'd1);
      default:  echo_last = 1'b1;
    endcase
  end

  always_comb begin
    st_nxt        = st_r;
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    echo_mode_nxt = echo_upd.valid ? echo_upd.mode : echo_mode_r;
    eseq_nxt      = eseq_r;
    ecnt_nxt      = ecnt_r;
    echr_nxt      = echr_r;
    jpend_nxt     = jpend_r;
    jovf_nxt      = jovf_r;
    jlen_nxt      = jlen_r;
    wr_en         = 1'b0;
    judge_start   = 1'b0;
    top_res       = '0;

    case (st_r)
      T_IDLE: begin
        if (accept) begin
          ecnt_nxt = 2'd0;
          echr_nxt = in_rx_byte;
          if (is_eol) begin
            // snapshot the line, then start a fresh one
            jpend_nxt = ovf_r || (fill_r != '0);
            jovf_nxt  = ovf_r;
            jlen_nxt  = fill_r;
            fill_nxt  = '0;
            ovf_nxt   = 1'b0;
            eseq_nxt  = ES_CRLF;
            if (echo_on) begin
              st_nxt = T_ECHO;
            end else if (ovf_r || (fill_r != '0)) begin
              st_nxt = T_LAUNCH;
            end
          end else if (is_erase) begin
            jpend_nxt = 1'b0;
            eseq_nxt  = ES_ERASE;
            if (fill_r != '0) begin
              fill_nxt = fill_r - 1'b1;
              if (echo_on) st_nxt = T_ECHO;
            end
          end else if (has_room) begin
            jpend_nxt = 1'b0;
            eseq_nxt  = ES_CHAR;
            wr_en     = 1'b1;
            fill_nxt  = fill_r + 1'b1;
            if (echo_on) st_nxt = T_ECHO;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      T_ECHO: begin
        if (slot_free) begin
          top_res.valid = 1'b1;
          top_res.kind  = K_ECHO;
          top_res.last  = echo_last && !jpend_r;
          case (eseq_r)
            ES_ERASE: top_res.ch = (ecnt_r == 2'd1) ? CH_SP : CH_BS;
            ES_CRLF:  top_res.ch = (ecnt_r == 2'd0) ? CH_CR : CH_LF;
            default:  top_res.ch = echr_r;
          endcase
          ecnt_nxt = ecnt_r + 2'd1;
          if (echo_last) st_nxt = jpend_r ? T_LAUNCH : T_IDLE;
        end
      end
      T_LAUNCH: begin
        if (jovf_r) begin
          st_nxt = T_OVF;
        end else begin
          judge_start = 1'b1;
          st_nxt      = T_JUDGE;
        end
      end
      T_OVF: begin
        if (slot_free) begin
          top_res.valid = 1'b1;
          top_res.kind  = K_ERROR;
          top_res.last  = 1'b1;
          st_nxt        = T_IDLE;
        end
      end
      T_JUDGE: begin
        if (judge_res.valid && judge_res.last) st_nxt = T_IDLE;
      end
      default: st_nxt = T_IDLE;
    endcase

    emit = top_res.valid ? top_res : judge_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      echo_mode_r <= EM_FOLLOW;
      cap_r       <= 7'd64;
      echo_def_r  <= 1'b1;
      jpend_r     <= 1'b0;
      jovf_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      echo_mode_r <= echo_mode_nxt;
      jpend_r     <= jpend_nxt;
      jovf_r      <= jovf_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LINE_CAPACITY: cap_r <= cfg_data;
          CFG_ECHO_DEFAULT:  echo_def_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (emit.valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    eseq_r <= eseq_nxt;
    ecnt_r <= ecnt_nxt;
    echr_r <= echr_nxt;
    jlen_r <= jlen_nxt;
    if (emit.valid) begin
      out_r <= emit;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_r.kind;
  assign out_char         = out_r.ch;
  assign out_request_type = out_r.rtype;
  assign out_last_of_run  = out_r.last;

  acp_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data (in_rx_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  acp_judge #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_judge (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (judge_start),
    .line_len  (jlen_r),
    .slot_free (slot_free),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res       (judge_res),
    .echo_upd  (echo_upd)
  );

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  import acp_pkg::*;

  // register indexes of the configuration port
  localparam logic REG_CAPACITY     = 1'b0;
  localparam logic REG_ECHO_DEFAULT = 1'b1;

  localparam int BUF_DEPTH   = 64;
  // A line end with a full buffer scans every kept char through the single
  // read port; the idle and tail waits below cover any word still in flight.
  localparam int IDLE_CYCLES = 300;
  localparam int TAIL_CYCLES = 300;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_REPORTS = 40;
  localparam int PHASE_WORDS = 5;

  // settings walked after the reset setting: capacity data and echo default,
  // plus whether the phase runs without any idling on either side
  localparam int N_PHASES = 6;
  localparam int PH_CAP   [N_PHASES] = '{0, 127, 5, 1, 64, 12};
  localparam int PH_ECHO  [N_PHASES] = '{0, 1, 0, 1, 0, 1};
  localparam int PH_BURST [N_PHASES] = '{0, 0, 1, 0, 0, 1};

  // one result word as seen on the out_ channel
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic [1:0] rtype;
    logic       last;
  } reply_t;

  // one stimulus row; when typed is set, up to three reply words are given
  // by hand (request type zero, last on the final one) instead of predicted
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    logic [1:0] n;
    logic [2:0] k0;
    logic [7:0] c0;
    logic [2:0] k1;
    logic [7:0] c1;
    logic [2:0] k2;
    logic [7:0] c2;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] out_kind;
  logic [7:0] out_char;
  logic [1:0] out_request_type;
  logic       out_last_of_run;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [6:0] cfg_data;

  at_command_line_parser_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_char         (out_char),
    .out_request_type (out_request_type),
    .out_last_of_run  (out_last_of_run),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------
  // Shadow of the parser: line buffer, fill, overflow flag, echo state and
  // the two registers. parse_rx fills line_words with the reply words one
  // received byte causes; reply_fifo holds every word still owed.
  // ---------------------------------------------------------------------
  logic [7:0]  ln_buf [BUF_DEPTH];
  int unsigned ln_fill;
  bit          ln_ovf;
  logic [1:0]  echo_state;
  logic [6:0]  cap_reg;
  bit          echo_def_reg;

  reply_t    line_words [$];
  reply_t    reply_fifo [$];
  stim_row_t stim_q     [$];

  int  n_errors   = 0;
  int  n_reports  = 0;
  int  n_checked  = 0;
  int  n_sent     = 0;
  int  n_settings = 1;
  int  cycles     = 0;
  int  stall_left = 0;
  bit  burst      = 1'b0;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= CH_UA && c <= CH_UZ) return c + 8'd32;
    return c;
  endfunction

  function automatic bit echo_is_on();
    if (echo_state == EM_OFF) return 1'b0;
    if (echo_state == EM_ON) return 1'b1;
    return echo_def_reg;
  endfunction

  // capacity register saturated to 2..depth
  function automatic int unsigned eff_cap();
    int unsigned c;
    c = 32'(cap_reg);
    if (c < 2) c = 2;
    if (c > BUF_DEPTH) c = BUF_DEPTH;
    return c;
  endfunction

  function automatic void emit(input logic [2:0] kind, input logic [7:0] ch,
                               input logic [1:0] rtype);
    reply_t w;
    w.kind  = kind;
    w.ch    = ch;
    w.rtype = rtype;
    w.last  = 1'b0;
    line_words.push_back(w);
  endfunction

  // verdict on a finished line; only the part before the first NUL counts
  function automatic void judge_line();
    int unsigned len;
    int unsigned sep;
    int unsigned i;
    logic [1:0]  rtype;
    bit          head;
    len = 0;
    while (len < ln_fill && len < BUF_DEPTH && ln_buf[len] != CH_NUL) len++;
    head = (len >= 2) && to_lower(ln_buf[0]) == CH_LA && to_lower(ln_buf[1]) == CH_LT;
    if (head && len == 2) begin
      emit(K_OK, CH_NUL, RT_EXEC);
      return;
    end
    if (head && len == 4 && to_lower(ln_buf[2]) == CH_LE) begin
      if (ln_buf[3] == CH_0) begin
        echo_state = EM_OFF;
        emit(K_OK, CH_NUL, RT_EXEC);
        return;
      end
      if (ln_buf[3] == CH_1) begin
        echo_state = EM_ON;
        emit(K_OK, CH_NUL, RT_EXEC);
        return;
      end
    end
    if (!head || len < 3 || ln_buf[2] != CH_PLUS) begin
      emit(K_ERROR, CH_NUL, RT_EXEC);
      return;
    end
    // first '=' or '?' splits name from the rest and fixes the type
    sep = 3;
    while (sep < len && ln_buf[sep] != CH_EQ && ln_buf[sep] != CH_QM) sep++;
    rtype = RT_EXEC;
    if (sep < len && ln_buf[sep] == CH_QM) begin
      if (sep + 1 != len) begin
        emit(K_ERROR, CH_NUL, RT_EXEC);
        return;
      end
      rtype = RT_QUERY;
    end else if (sep < len) begin
      rtype = RT_SET;
    end
    for (i = 3; i < sep; i++) emit(K_NAME, ln_buf[i], rtype);
    if (rtype == RT_SET)
      for (i = sep + 1; i < len; i++) emit(K_ARG, ln_buf[i], rtype);
    emit(K_END, CH_NUL, rtype);
  endfunction

  function automatic void parse_rx(input logic [7:0] c);
    reply_t w;
    line_words.delete();
    if (c == CH_CR || c == CH_LF) begin
      // line end echo uses the echo setting from before the verdict
      if (echo_is_on()) begin
        emit(K_ECHO, CH_CR, RT_EXEC);
        emit(K_ECHO, CH_LF, RT_EXEC);
      end
      if (ln_ovf) emit(K_ERROR, CH_NUL, RT_EXEC);
      else if (ln_fill > 0) judge_line();
      ln_fill = 0;
      ln_ovf  = 1'b0;
    end else if (c == CH_BS || c == CH_DEL) begin
      // erase on an empty line is silently dropped
      if (ln_fill > 0) begin
        ln_fill--;
        if (echo_is_on()) begin
          emit(K_ECHO, CH_BS, RT_EXEC);
          emit(K_ECHO, CH_SP, RT_EXEC);
          emit(K_ECHO, CH_BS, RT_EXEC);
        end
      end
    end else if (ln_fill + 1 < eff_cap() && ln_fill < BUF_DEPTH) begin
      ln_buf[ln_fill] = c;
      ln_fill++;
      if (echo_is_on()) emit(K_ECHO, c, RT_EXEC);
    end else begin
      ln_ovf = 1'b1;
    end
    if (line_words.size() > 0) begin
      w = line_words.pop_back();
      w.last = 1'b1;
      line_words.push_back(w);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic void push_byte(input logic [7:0] b);
    stim_q.push_back('{b, 1'b0, 2'd0, K_ECHO, CH_NUL, K_ECHO, CH_NUL, K_ECHO, CH_NUL});
  endfunction

  function automatic logic [7:0] any_case(input logic [7:0] lc);
    return $urandom_range(0, 1) ? lc - 8'd32 : lc;
  endfunction

  function automatic logic [7:0] name_char();
    if ($urandom_range(0, 3) == 0) return CH_0 + 8'($urandom_range(0, 9));
    return any_case(CH_LA + 8'($urandom_range(0, 25)));
  endfunction

  function automatic int draw_gap();
    return burst ? 0 : $urandom_range(0, 4);
  endfunction

  // One random line. Most are well formed (AT, ATE0/1, AT+ with exec, query
  // or set, now and then a long name), the rest broken or plain noise.
  // Some get an erased char or a NUL spliced in.
  task automatic gen_line();
    logic [7:0] ln [$];
    int         form;
    int         nlen;
    int         i;
    int         erase_at;
    int         nul_at;
    int         sel;
    form = $urandom_range(0, 19);
    ln.push_back(any_case(CH_LA));
    ln.push_back(any_case(CH_LT));
    if (form < 2) begin
      // bare AT
    end else if (form < 4) begin
      ln.push_back(any_case(CH_LE));
      if ($urandom_range(0, 5) == 0) ln.push_back(CH_1 + 8'd1);
      else ln.push_back($urandom_range(0, 1) ? CH_1 : CH_0);
    end else if (form < 15) begin
      ln.push_back(CH_PLUS);
      nlen = (form == 14) ? $urandom_range(30, 66) : $urandom_range(0, 6);
      for (i = 0; i < nlen; i++) ln.push_back(name_char());
      sel = $urandom_range(0, 2);
      if (sel == 1) begin
        ln.push_back(CH_QM);
      end else if (sel == 2) begin
        ln.push_back(CH_EQ);
        nlen = $urandom_range(0, 8);
        for (i = 0; i < nlen; i++) ln.push_back(8'($urandom_range(32, 126)));
      end
    end else if (form < 17) begin
      // either no '+' at all, or a '?' with more after it
      if ($urandom_range(0, 1)) begin
        ln.push_back(CH_PLUS);
        ln.push_back(name_char());
        ln.push_back(CH_QM);
      end
      ln.push_back(name_char());
      ln.push_back(name_char());
    end else begin
      ln.delete();
      nlen = $urandom_range(1, 10);
      for (i = 0; i < nlen; i++) ln.push_back(8'($urandom_range(0, 255)));
    end
    erase_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, ln.size()) : -1;
    nul_at   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ln.size() - 1) : -1;
    for (i = 0; i <= ln.size(); i++) begin
      if (i == erase_at) begin
        push_byte(name_char());
        push_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
      end
      if (i == nul_at) push_byte(CH_NUL);
      if (i < ln.size()) push_byte(ln[i]);
    end
    if (form < 17 || $urandom_range(0, 1)) push_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
  endtask

  task automatic gen_phase();
    stim_q.delete();
    while (stim_q.size() < PHASE_WORDS) gen_line();
    // half the time leave a line open so the next setting lands mid-line
    if ($urandom_range(0, 1)) begin
      push_byte(CH_UA);
      push_byte(CH_LT);
      push_byte(CH_PLUS);
      push_byte(name_char());
    end
  endtask

  // ---------------------------------------------------------------------
  // Input driver. in_valid stays high across back-to-back words; a new
  // payload then lands in the same step as the acceptance.
  // ---------------------------------------------------------------------
  task automatic send_words();
    int        gap;
    int        idx;
    int        j;
    stim_row_t row;
    reply_t    w;
    gap = draw_gap();
    for (idx = 0; idx < stim_q.size(); idx++) begin
      row = stim_q[idx];
      if (gap > 0) repeat (gap) @(posedge clk);
      in_valid   <= 1'b1;
      in_rx_byte <= row.rx;
      do @(posedge clk); while (!in_ready);
      n_sent++;
      parse_rx(row.rx);
      if (row.typed) begin
        // hand-written replies replace the prediction; state still advances
        line_words.delete();
        for (j = 0; j < row.n; j++) begin
          w.kind  = (j == 0) ? row.k0 : (j == 1) ? row.k1 : row.k2;
          w.ch    = (j == 0) ? row.c0 : (j == 1) ? row.c1 : row.c2;
          w.rtype = RT_EXEC;
          w.last  = (j == row.n - 1);
          line_words.push_back(w);
        end
      end
      foreach (line_words[k]) reply_fifo.push_back(line_words[k]);
      gap = draw_gap();
      if (gap > 0 || idx == stim_q.size() - 1) in_valid <= 1'b0;
    end
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (reply_fifo.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_CAPACITY) cap_reg = data;
    else echo_def_reg = data[0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // registers change only with the parser quiet: every owed word has come
  // and enough cycles have passed for a silent line end to finish
  task automatic apply_setting(input int cap, input int echo_def);
    wait_drained();
    repeat (IDLE_CYCLES) @(posedge clk);
    write_reg(REG_CAPACITY, cap[6:0]);
    write_reg(REG_ECHO_DEFAULT, echo_def[6:0]);
    n_settings++;
  endtask

  // ---------------------------------------------------------------------
  // Output side: random stalls per word, and the comparison against the
  // oldest owed word.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_kind, out_char, out_request_type, out_last_of_run};
      if (reply_fifo.size() == 0) begin
        n_errors++;
        if (n_reports < MAX_REPORTS)
          $display("%0t: unexpected word kind=%0d char=%h type=%0d last=%0d", $time,
                   got.kind, got.ch, got.rtype, got.last);
        n_reports++;
      end else begin
        want = reply_fifo.pop_front();
        n_checked++;
        if (got !== want) begin
          n_errors++;
          if (n_reports < MAX_REPORTS)
            $display("%0t: expected kind=%0d char=%h type=%0d last=%0d,",
                     $time, want.kind, want.ch, want.rtype, want.last,
                     " got kind=%0d char=%h type=%0d last=%0d",
                     got.kind, got.ch, got.rtype, got.last);
          n_reports++;
        end
      end
      stall_left = burst ? 0 : $urandom_range(0, 4);
    end
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int p;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= CH_NUL;
    out_ready  <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_CAPACITY;
    cfg_data   <= 7'd0;
    foreach (ln_buf[i]) ln_buf[i] = CH_NUL;
    ln_fill      = 0;
    ln_ovf       = 1'b0;
    echo_state   = EM_FOLLOW;
    cap_reg      = 7'd64;
    echo_def_reg = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines at the reset setting (capacity 64, echo on).
    stim_q.delete();
    stim_q.push_back('{CH_LA, 1'b1, 2'd1, K_ECHO, CH_LA, K_ECHO, CH_NUL, K_ECHO, CH_NUL});
    stim_q.push_back('{"T", 1'b1, 2'd1, K_ECHO, "T", K_ECHO, CH_NUL, K_ECHO, CH_NUL});
    // mixed-case AT answers OK after the CR LF echo
    stim_q.push_back('{CH_CR, 1'b1, 2'd3, K_ECHO, CH_CR, K_ECHO, CH_LF, K_OK, CH_NUL});
    stim_q.push_back('{8'hFF, 1'b1, 2'd1, K_ECHO, 8'hFF, K_ECHO, CH_NUL, K_ECHO, CH_NUL});
    stim_q.push_back('{CH_DEL, 1'b1, 2'd3, K_ECHO, CH_BS, K_ECHO, CH_SP, K_ECHO, CH_BS});
    // erase on an empty line: nothing at all
    stim_q.push_back('{CH_BS, 1'b1, 2'd0, K_ECHO, CH_NUL, K_ECHO, CH_NUL, K_ECHO, CH_NUL});
    // empty line end: only the echo
    stim_q.push_back('{CH_LF, 1'b1, 2'd2, K_ECHO, CH_CR, K_ECHO, CH_LF, K_ECHO, CH_NUL});
    push_byte(CH_UA);
    push_byte(CH_LT);
    push_byte(CH_LE);
    push_byte(CH_0);
    // ATE0: echo of the line end still on, then echo goes off
    stim_q.push_back('{CH_CR, 1'b1, 2'd3, K_ECHO, CH_CR, K_ECHO, CH_LF, K_OK, CH_NUL});
    stim_q.push_back('{CH_UA, 1'b1, 2'd0, K_ECHO, CH_NUL, K_ECHO, CH_NUL, K_ECHO, CH_NUL});
    push_byte("T");
    push_byte(CH_PLUS);
    push_byte(CH_QM);
    push_byte("x");
    // '?' that is not last
    stim_q.push_back('{CH_CR, 1'b1, 2'd1, K_ERROR, CH_NUL, K_ECHO, CH_NUL, K_ECHO, CH_NUL});
    // empty name, set whose argument is a '?'
    push_byte(CH_LA);
    push_byte(CH_LT);
    push_byte(CH_PLUS);
    push_byte(CH_EQ);
    push_byte(CH_QM);
    push_byte(CH_CR);
    // leading NUL: the next line is judged as empty text
    push_byte(CH_NUL);
    send_words();

    // sender holds off until every owed word has come back
    wait_drained();

    gen_phase();
    send_words();
    for (p = 0; p < N_PHASES; p++) begin
      apply_setting(PH_CAP[p], PH_ECHO[p]);
      burst = (PH_BURST[p] != 0);
      gen_phase();
      send_words();
    end
    burst = 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run: %0d input words over %0d register settings, %0d result words compared",
             n_sent, n_settings, n_checked);
    $display("run: capacity 2..64 with overflow, echo on/off, erase, NUL, AT/ATE/AT+ lines");
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
